// ----- sv/absyn_pkg.sv -----
// Package: constants, tables and register codes of the additive bell synthesizer.
`timescale 1ns / 1ps

package absyn_pkg;

  localparam int unsigned STEP_W     = 24;
  localparam int unsigned INTERVAL_W = 17;
  localparam int unsigned ENV_W      = 16;
  localparam int unsigned SAMPLE_W   = 16;

  // Only the first four partials have nonzero amplitude.
  localparam int unsigned MAX_PARTIALS = 4;

  // Shared multiplier operand widths (signed).
  localparam int unsigned MUL_A_W = 35;
  localparam int unsigned MUL_B_W = 27;

  // Reciprocal scale for the final constant division.
  localparam int unsigned RECIP_SHIFT = 26;

  // Envelope amplitudes, Q1.15.
  localparam logic [ENV_W-1:0] AMP [MAX_PARTIALS] = '{
    16'd32768, 16'd16384, 16'd9830, 16'd4915
  };

  // Per-partial decay factors, Q0.16.
  localparam logic [15:0] DECAY [MAX_PARTIALS] = '{
    16'd64780, 16'd64280, 16'd63661, 16'd61840
  };

  localparam logic [STEP_W-1:0] STEP_RESET [MAX_PARTIALS] = '{
    24'd334783, 24'd669567, 24'd924078, 24'd1807830
  };

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 17'd66150;
  localparam logic [INTERVAL_W-1:0] ELAPSED_MAX    = 17'h1FFFF;

  // Quarter-wave polynomial coefficients.
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [15:0] SIN_B = 16'd21167;
  localparam logic [15:0] SIN_C = 16'd2463;

  // Register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_STEP_FUND   = 3'd0;
  localparam logic [2:0] REG_STEP_OCTAVE = 3'd1;
  localparam logic [2:0] REG_STEP_TIERCE = 3'd2;
  localparam logic [2:0] REG_STEP_QUINT  = 3'd3;
  localparam logic [2:0] REG_INTERVAL    = 3'd4;

endpackage

// ----- sv/additive_bell_synth_top.sv -----
// Top level: additive bell synthesizer with one shared multiplier under a sequencer.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i/in_ready_o, volume_delta_i): one transfer asks for one
//   audio frame; the delta is applied to the volume level before the frame is mixed.
//   Output channel (out_valid_o/out_ready_i, sample_o, strike_o): one transfer per frame.
//   APB port: phase steps of the four partials at 0x00..0x0C, retrigger interval at
//   0x10. Write only while no frame is in flight.
// Timing
//   One 35x27 multiplier does all work: five products per partial for sine and mix,
//   three for the final gain and constant division, plus one per partial for the
//   envelope decay on the first frame of a buffer where decay applies.
//   Up to four partials are active. A new frame is taken only once the previous one
//   has left the sequencer; in_ready_o is high only when idle.
// Reset
//   Phases and counters clear, envelopes load full amplitude, volume is four and the
//   registers take their defaults; the first frame raises no strike, as elapsed starts below the interval.
// Stall
//   The result sits in an output register, so the next frame is accepted while it
//   waits; a finished frame holds in the last step until that register frees up.

module additive_bell_synth_top
  import absyn_pkg::*;
#(
  parameter int PARTIALS          = 4,
  parameter int FRAMES_PER_BUFFER = 256,
  parameter int VOLUME_MAX        = 20,
  parameter int SINE_TABLE_BITS   = 10,
  parameter int PHASE_BITS        = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [5:0]          volume_delta_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic                       strike_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int NP        = (PARTIALS > int'(MAX_PARTIALS)) ? int'(MAX_PARTIALS) : PARTIALS;
  localparam int KW        = (NP > 1) ? $clog2(NP) : 1;
  localparam int FW        = (FRAMES_PER_BUFFER > 1) ? $clog2(FRAMES_PER_BUFFER) : 1;
  localparam int VW        = $clog2(VOLUME_MAX + 1);
  localparam int GW        = VW + 15;
  localparam int DIVISOR   = 2 * VOLUME_MAX;
  localparam int RECIP     = (1 << RECIP_SHIFT) / DIVISOR;
  localparam int SAT_LIMIT = 32768 * DIVISOR;
  localparam int PW        = SINE_TABLE_BITS - 1;
  localparam int QLEN      = 1 << (SINE_TABLE_BITS - 2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECAY,
    ST_SQ,
    ST_T1,
    ST_T2,
    ST_Y,
    ST_MIX,
    ST_NUM,
    ST_REC,
    ST_CORR
  } state_e;

  state_e                   state_q;
  logic [KW-1:0]            k_q;
  logic [PHASE_BITS-1:0]    phase_q [NP];
  logic [ENV_W-1:0]         env_q [NP];
  logic [STEP_W-1:0]        step_q [MAX_PARTIALS];
  logic [INTERVAL_W-1:0]    interval_q;
  logic [INTERVAL_W-1:0]    elapsed_q;
  logic [FW-1:0]            fib_q;
  logic [VW-1:0]            vol_q;
  logic [GW-1:0]            g_q;
  logic                     strike_pend_q;
  logic signed [35:0]       mix_q;
  logic [15:0]              x_q;
  logic [15:0]              x2_q;
  logic [15:0]              t_q;
  logic signed [15:0]       s_q;
  logic                     sneg_q;
  logic [22:0]              q1_q;
  logic                     sat_q;
  logic                     mneg_q;
  logic [14:0]              est_q;
  logic                     out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                     strike_q;

  logic                     cfg_wr;
  logic                     in_xfer;
  logic                     out_stall;
  logic                     last_part;
  logic                     boundary;
  logic                     retrig;
  logic                     decay_go;
  logic signed [7:0]        vol_ext;
  logic signed [7:0]        dlt_ext;
  logic signed [7:0]        vol_sum;
  logic [VW-1:0]            vol_new;
  logic [INTERVAL_W-1:0]    elapsed_inc;
  logic [PHASE_BITS-1:0]    phase_sel;
  logic [PHASE_BITS-1:0]    step_sel;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [PW-1:0]            pos_m;
  logic [15:0]              x_val;
  logic [16:0]              y_raw;
  logic [14:0]              y_cap;
  logic [35:0]              mix_abs;
  logic [21:0]              rem;
  logic [14:0]              est_fix;
  logic [14:0]              mag;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [61:0]       prod;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_stall   = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign strike_o    = strike_q;
  assign last_part   = (k_q == KW'(NP - 1));

  always_comb begin
    unique case (paddr[4:2])
      REG_STEP_FUND:   prdata = 32'(step_q[0]);
      REG_STEP_OCTAVE: prdata = 32'(step_q[1]);
      REG_STEP_TIERCE: prdata = 32'(step_q[2]);
      REG_STEP_QUINT:  prdata = 32'(step_q[3]);
      REG_INTERVAL:    prdata = 32'(interval_q);
      default:         prdata = '0;
    endcase
  end

  // Frame setup decisions, taken on the input transfer.
  always_comb begin
    vol_ext  = signed'(8'(vol_q));
    dlt_ext  = 8'(volume_delta_i);
    vol_sum  = vol_ext + dlt_ext;
    if (vol_sum < 8'sd0) begin
      vol_new = '0;
    end else if (vol_sum > signed'(8'(VOLUME_MAX))) begin
      vol_new = VW'(VOLUME_MAX);
    end else begin
      vol_new = VW'(vol_sum);
    end
    boundary    = (fib_q == '0);
    retrig      = boundary && (elapsed_q >= interval_q);
    decay_go    = boundary && !retrig && (elapsed_q != '0);
    elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
  end

  // Sine argument: quadrant fold of the top phase bits.
  always_comb begin
    phase_sel = phase_q[k_q];
    step_sel  = PHASE_BITS'(step_q[2'(k_q)]);
    idx       = phase_sel[PHASE_BITS-1 -: SINE_TABLE_BITS];
    if (idx[SINE_TABLE_BITS-2]) begin
      pos_m = PW'(QLEN) - PW'(idx[SINE_TABLE_BITS-3:0]);
    end else begin
      pos_m = PW'(idx[SINE_TABLE_BITS-3:0]);
    end
    x_val = 16'(pos_m) << (17 - SINE_TABLE_BITS);
  end

  // Shared multiplier operand select.
  always_comb begin
    mix_abs = mix_q[35] ? 36'(-mix_q) : 36'(mix_q);
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      ST_DECAY: begin
        mul_a = MUL_A_W'(env_q[k_q]);
        mul_b = MUL_B_W'(DECAY[2'(k_q)]);
      end
      ST_SQ: begin
        mul_a = MUL_A_W'(x_val);
        mul_b = MUL_B_W'(x_val);
      end
      ST_T1: begin
        mul_a = MUL_A_W'(x2_q);
        mul_b = MUL_B_W'(SIN_C);
      end
      ST_T2: begin
        mul_a = MUL_A_W'(x2_q);
        mul_b = MUL_B_W'(t_q);
      end
      ST_Y: begin
        mul_a = MUL_A_W'(x_q);
        mul_b = MUL_B_W'(t_q);
      end
      ST_MIX: begin
        mul_a = MUL_A_W'(env_q[k_q]);
        mul_b = MUL_B_W'(s_q);
      end
      ST_NUM: begin
        mul_a = MUL_A_W'(mix_abs[34:0]);
        mul_b = MUL_B_W'(g_q);
      end
      ST_REC: begin
        mul_a = MUL_A_W'(q1_q);
        mul_b = MUL_B_W'(RECIP);
      end
      ST_CORR: begin
        mul_a = MUL_A_W'(est_q);
        mul_b = MUL_B_W'(DIVISOR);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Post-processing of the product.
  always_comb begin
    y_raw   = prod[31:15];
    y_cap   = (y_raw > 17'd32767) ? 15'h7FFF : y_raw[14:0];
    rem     = q1_q[21:0] - prod[21:0];
    est_fix = (rem >= 22'(DIVISOR)) ? est_q + 1'b1 : est_q;
    mag     = sat_q ? 15'h7FFF : est_fix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      k_q           <= '0;
      for (int i = 0; i < NP; i++) begin
        phase_q[i] <= '0;
        env_q[i]   <= AMP[i];
      end
      for (int i = 0; i < int'(MAX_PARTIALS); i++) begin
        step_q[i] <= STEP_RESET[i];
      end
      interval_q    <= INTERVAL_RESET;
      elapsed_q     <= '0;
      fib_q         <= '0;
      vol_q         <= VW'(4);
      g_q           <= '0;
      strike_pend_q <= 1'b0;
      mix_q         <= '0;
      x_q           <= '0;
      x2_q          <= '0;
      t_q           <= '0;
      s_q           <= '0;
      sneg_q        <= 1'b0;
      q1_q          <= '0;
      sat_q         <= 1'b0;
      mneg_q        <= 1'b0;
      est_q         <= '0;
      out_valid_q   <= 1'b0;
      sample_q      <= '0;
      strike_q      <= 1'b0;
    end else begin
      g_q <= GW'({vol_q, 15'b0}) - GW'(vol_q);

      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_STEP_FUND:   step_q[0]  <= pwdata[STEP_W-1:0];
          REG_STEP_OCTAVE: step_q[1]  <= pwdata[STEP_W-1:0];
          REG_STEP_TIERCE: step_q[2]  <= pwdata[STEP_W-1:0];
          REG_STEP_QUINT:  step_q[3]  <= pwdata[STEP_W-1:0];
          REG_INTERVAL:    interval_q <= pwdata[INTERVAL_W-1:0];
          default: ;
        endcase
      end

      // ST_CORR reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != ST_CORR)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            vol_q         <= vol_new;
            strike_pend_q <= retrig;
            mix_q         <= '0;
            k_q           <= '0;
            elapsed_q     <= retrig ? INTERVAL_W'(1) : elapsed_inc;
            fib_q         <= (fib_q == FW'(FRAMES_PER_BUFFER - 1)) ? '0 : fib_q + 1'b1;
            if (retrig) begin
              for (int i = 0; i < NP; i++) begin
                phase_q[i] <= '0;
                env_q[i]   <= AMP[i];
              end
            end
            state_q <= decay_go ? ST_DECAY : ST_SQ;
          end
        end
        ST_DECAY: begin
          env_q[k_q] <= prod[31:16];
          if (last_part) begin
            k_q     <= '0;
            state_q <= ST_SQ;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_SQ: begin
          x_q     <= x_val;
          sneg_q  <= idx[SINE_TABLE_BITS-1];
          x2_q    <= prod[30:15];
          state_q <= ST_T1;
        end
        ST_T1: begin
          t_q     <= SIN_B - prod[30:15];
          state_q <= ST_T2;
        end
        ST_T2: begin
          t_q     <= SIN_A - prod[30:15];
          state_q <= ST_Y;
        end
        ST_Y: begin
          s_q     <= sneg_q ? -signed'(16'(y_cap)) : signed'(16'(y_cap));
          state_q <= ST_MIX;
        end
        ST_MIX: begin
          mix_q        <= mix_q + signed'(prod[35:0]);
          phase_q[k_q] <= phase_sel + step_sel;
          if (last_part) begin
            k_q     <= '0;
            state_q <= ST_NUM;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_SQ;
          end
        end
        ST_NUM: begin
          q1_q    <= prod[52:30];
          sat_q   <= (prod[52:30] >= 23'(SAT_LIMIT));
          mneg_q  <= mix_q[35];
          state_q <= ST_REC;
        end
        ST_REC: begin
          est_q   <= prod[RECIP_SHIFT+14:RECIP_SHIFT];
          state_q <= ST_CORR;
        end
        ST_CORR: begin
          if (!out_stall) begin
            sample_q    <= mneg_q ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
            strike_q    <= strike_pend_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
